>>> src/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed: invariant");

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHK_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: implication");

`endif

>>> src/ffra_pkg.sv
package ffra_pkg;

   localparam int MAP_ENTRIES = 32;
   localparam int HEAP_BYTES  = 65536;
   localparam int ALIGN_BYTES = 16;

   localparam int IDX_W = $clog2(MAP_ENTRIES);
   localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
   localparam int OFF_W = 16;
   localparam int LEN_W = $clog2(HEAP_BYTES + 1);

   localparam logic [LEN_W-1:0] ALIGN_LEN  = LEN_W'(ALIGN_BYTES);
   localparam logic [LEN_W-1:0] ALIGN_MASK = ~(ALIGN_LEN - LEN_W'(1));

   localparam logic [1:0] FN_ALLOC = 2'd0;
   localparam logic [1:0] FN_FREE  = 2'd1;
   localparam logic [1:0] FN_INIT  = 2'd2;

   localparam logic [2:0] ST_GRANTED = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_FREED   = 3'd2;
   localparam logic [2:0] ST_IGNORED = 3'd3;
   localparam logic [2:0] ST_INIT    = 3'd4;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] length;
      logic             used;
   } entry_type;

   typedef struct packed {
      logic      hit;
      logic      roomy;
      entry_type tail;
   } eval_type;

   localparam entry_type INIT_ENTRY = '{offset: '0, length: LEN_W'(HEAP_BYTES), used: 1'b0};

   // Rounds a byte count up to the alignment; zero becomes one alignment unit.
   function automatic logic [LEN_W-1:0] need_of(input logic [OFF_W-1:0] size);
      logic [LEN_W-1:0] up;
      up = (LEN_W'(size) + ALIGN_LEN - LEN_W'(1)) & ALIGN_MASK;
      if (up == '0) begin
         up = ALIGN_LEN;
      end
      return up;
   endfunction

endpackage

>>> src/ffra_table.sv
module ffra_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ffra_pkg::IDX_W-1:0] wr_addr,
   input  ffra_pkg::entry_type        wr_data,
   input  logic [ffra_pkg::IDX_W-1:0] rd_addr,
   output ffra_pkg::entry_type        rd_data
);
   import ffra_pkg::*;

   entry_type store_ff [MAP_ENTRIES];
   entry_type rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ffra_eval.sv
module ffra_eval (
   input  logic [1:0]                 func,
   input  logic [ffra_pkg::LEN_W-1:0] need,
   input  logic [ffra_pkg::OFF_W-1:0] address,
   input  ffra_pkg::entry_type        entry,
   output ffra_pkg::eval_type         result
);
   import ffra_pkg::*;

   logic [LEN_W:0] limit;

   // Allocation looks for a free region that is long enough; a free looks for
   // a used region that starts at the given offset.
   always_comb begin
      limit = {1'b0, need} + {1'b0, ALIGN_LEN};
      if (func == FN_ALLOC) begin
         result.hit = !entry.used && (entry.length >= need);
      end else begin
         result.hit = entry.used && (entry.offset == address);
      end
      result.roomy       = {1'b0, entry.length} > limit;
      result.tail.offset = entry.offset + need[OFF_W-1:0];
      result.tail.length = entry.length - need;
      result.tail.used   = 1'b0;
   end

endmodule

>>> src/first_fit_region_allocator.sv
// First-fit heap region allocator.
// A request word (req_func, req_request_size, req_address, req_null_pointer)
// is taken at a rising edge with start high and busy low. Allocate rounds the
// size up to the 16-byte alignment and grants the first free region that is long
// enough, splitting off the tail as a new free region when it is over 16 bytes
// and the 32-entry table has room. Free releases the used region starting at
// req_address and merges it with free neighbours. Reinitialise restores one
// free region. Each request gives exactly one result word, shown for one cycle
// with rsp_valid high; the receiver cannot stall, so it must take the word in
// that cycle. A request ignored at once (an unknown function or a free of a
// null pointer) answers in the cycle after it is taken and leaves busy low.
// A reinitialise passes through the init state, which rewrites the table and
// issues the result word. Allocate and free take longer the more table entries
// are in use; the single read port of the region table sets their pace: the scan
// reads one entry a cycle, and an insertion or removal moves the entries behind
// it one at a time. Other requests keep busy high until the result word is issued.
// After reset the boot state writes the initial region, busy high, no result word.
module first_fit_region_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_func,
   input  logic [15:0]                 req_request_size,
   input  logic [15:0]                 req_address,
   input  logic                        req_null_pointer,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [15:0]                 rsp_block_offset,
   output logic [ffra_pkg::CNT_W-1:0]  rsp_entries_in_use
);
   import ffra_pkg::*;

   typedef enum logic [2:0] {
      S_BOOT, S_INIT, S_IDLE, S_SCAN, S_MERGE, S_SHIFT_DN, S_SHIFT_UP, S_SPLIT
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       func_ff, func_in;
   logic [LEN_W-1:0] need_ff, need_in;
   logic [OFF_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] tag_ff, tag_in;
   logic             vld_ff, vld_in;
   logic [CNT_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        cur_ff, cur_in;
   entry_type        prev_ff, prev_in;
   entry_type        tail_ff, tail_in;
   logic [1:0]       shift_ff, shift_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic             wr_en;
   logic [CNT_W-1:0] wr_idx;
   entry_type        wr_data;
   entry_type        rd_data;
   eval_type         ev;
   logic             split;
   logic             pfree;
   logic             nfree;
   logic [LEN_W-1:0] merged_len;

   ffra_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // The shared compare unit judges each entry as it comes back from the table.
   ffra_eval u_eval (
      .func    (func_ff),
      .need    (need_ff),
      .address (addr_ff),
      .entry   (rd_data),
      .result  (ev)
   );

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      tag_in        = ptr_ff;
      vld_in        = 1'b0;
      hit_idx_in    = hit_idx_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      tail_in       = tail_ff;
      shift_in      = shift_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_data       = INIT_ENTRY;
      split         = ev.roomy && (cnt_ff < CNT_W'(MAP_ENTRIES));
      // A merge takes in the region before the freed one and the one after it
      // when they are free; the table never holds two free neighbours.
      pfree         = (hit_idx_ff != '0) && !prev_ff.used;
      nfree         = vld_ff && !rd_data.used;
      merged_len    = (pfree ? prev_ff.length : '0) + cur_ff.length
                      + (nfree ? rd_data.length : '0);

      unique case (state_ff)
         S_BOOT: begin
            wr_en    = 1'b1;
            cnt_in   = CNT_W'(1);
            state_in = S_IDLE;
         end

         S_INIT: begin
            wr_en         = 1'b1;
            cnt_in        = CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_INIT;
            rsp_offset_in = '0;
            rsp_count_in  = CNT_W'(1);
            state_in      = S_IDLE;
         end

         S_IDLE: begin
            if (start) begin
               func_in = req_func;
               need_in = need_of(req_request_size);
               addr_in = req_address;
               ptr_in  = '0;
               prev_in = INIT_ENTRY;
               priority if (req_func == FN_INIT) begin
                  state_in = S_INIT;
               end else if (req_func == FN_ALLOC
                            || (req_func == FN_FREE && !req_null_pointer)) begin
                  state_in = S_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_IGNORED;
                  rsp_offset_in = '0;
                  rsp_count_in  = cnt_ff;
               end
            end
         end

         S_SCAN: begin
            // Read one entry a cycle; the data for entry tag_ff arrives now.
            if (ptr_ff < cnt_ff) begin
               vld_in = 1'b1;
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (vld_ff && ev.hit) begin
               hit_idx_in = tag_ff;
               cur_in     = rd_data;
               if (func_ff == FN_ALLOC) begin
                  wr_en          = 1'b1;
                  wr_idx         = tag_ff;
                  wr_data.offset = rd_data.offset;
                  wr_data.length = split ? need_ff : rd_data.length;
                  wr_data.used   = 1'b1;
                  tail_in        = ev.tail;
                  if (!split) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_GRANTED;
                     rsp_offset_in = rd_data.offset;
                     rsp_count_in  = cnt_ff;
                     state_in      = S_IDLE;
                  end else if (tag_ff + CNT_W'(1) < cnt_ff) begin
                     vld_in   = 1'b0;
                     ptr_in   = cnt_ff - CNT_W'(1);
                     state_in = S_SHIFT_UP;
                  end else begin
                     vld_in   = 1'b0;
                     state_in = S_SPLIT;
                  end
               end else begin
                  // The read of the following entry is already under way.
                  state_in = S_MERGE;
               end
            end else if (vld_ff) begin
               prev_in = rd_data;
            end else if (ptr_ff >= cnt_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (func_ff == FN_ALLOC) ? ST_NOFIT : ST_IGNORED;
               rsp_offset_in = '0;
               rsp_count_in  = cnt_ff;
               state_in      = S_IDLE;
            end
         end

         S_MERGE: begin
            wr_en          = 1'b1;
            wr_idx         = pfree ? hit_idx_ff - CNT_W'(1) : hit_idx_ff;
            wr_data.offset = pfree ? prev_ff.offset : cur_ff.offset;
            wr_data.length = merged_len;
            wr_data.used   = 1'b0;
            shift_in       = {1'b0, pfree} + {1'b0, nfree};
            ptr_in         = hit_idx_ff + CNT_W'(1) + CNT_W'(nfree);
            if (!pfree && !nfree) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FREED;
               rsp_offset_in = '0;
               rsp_count_in  = cnt_ff;
               state_in      = S_IDLE;
            end else begin
               state_in = S_SHIFT_DN;
            end
         end

         S_SHIFT_DN: begin
            // Close the gap left by the merged entries, lowest entry first.
            if (ptr_ff < cnt_ff) begin
               vld_in = 1'b1;
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (vld_ff) begin
               wr_en   = 1'b1;
               wr_idx  = tag_ff - CNT_W'(shift_ff);
               wr_data = rd_data;
            end else if (ptr_ff >= cnt_ff) begin
               cnt_in        = cnt_ff - CNT_W'(shift_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FREED;
               rsp_offset_in = '0;
               rsp_count_in  = cnt_ff - CNT_W'(shift_ff);
               state_in      = S_IDLE;
            end
         end

         S_SHIFT_UP: begin
            // Open a slot behind the granted region, highest entry first.
            if (ptr_ff > hit_idx_ff) begin
               vld_in = 1'b1;
               ptr_in = ptr_ff - CNT_W'(1);
            end
            if (vld_ff) begin
               wr_en   = 1'b1;
               wr_idx  = tag_ff + CNT_W'(1);
               wr_data = rd_data;
            end else if (ptr_ff <= hit_idx_ff) begin
               state_in = S_SPLIT;
            end
         end

         S_SPLIT: begin
            wr_en         = 1'b1;
            wr_idx        = hit_idx_ff + CNT_W'(1);
            wr_data       = tail_ff;
            cnt_in        = cnt_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_GRANTED;
            rsp_offset_in = cur_ff.offset;
            rsp_count_in  = cnt_ff + CNT_W'(1);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         cnt_ff       <= CNT_W'(1);
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      ptr_ff        <= ptr_in;
      tag_ff        <= tag_in;
      hit_idx_ff    <= hit_idx_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      tail_ff       <= tail_in;
      shift_ff      <= shift_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_block_offset   = rsp_offset_ff;
   assign rsp_entries_in_use = rsp_count_ff;

endmodule

>>> src/ffra_checker.sv
`include "assert_macros.svh"

module ffra_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [2:0]                 rsp_status,
   input logic [15:0]                rsp_block_offset,
   input logic [ffra_pkg::CNT_W-1:0] rsp_entries_in_use
);
   import ffra_pkg::*;

   `CHK_IMPLIES(a_status_known, clock, reset, rsp_valid, rsp_status <= ST_INIT)
   `CHK_IMPLIES(a_offset_zero, clock, reset,
                rsp_valid && rsp_status != ST_GRANTED, rsp_block_offset == '0)
   `CHK_IMPLIES(a_init_count, clock, reset,
                rsp_valid && rsp_status == ST_INIT, rsp_entries_in_use == CNT_W'(1))
   `CHK_IMPLIES(a_count_range, clock, reset, rsp_valid,
                rsp_entries_in_use != '0 && rsp_entries_in_use <= CNT_W'(MAP_ENTRIES))
   `CHK_IMPLIES(a_init_answer, clock, reset,
                start && !busy && $past(start && !busy) && $past(rsp_valid)
                && rsp_valid && rsp_status == ST_INIT,
                $past(rsp_status) != ST_INIT || $past(rsp_entries_in_use) == CNT_W'(1))

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_block_offset   (rsp_block_offset),
   .rsp_entries_in_use (rsp_entries_in_use)
);
